// ----- design/i2c_bus_monitor_defines.svh -----
// Assertion macros used by the checker file of the bus monitor.
`ifndef I2C_BUS_MONITOR_DEFINES_SVH
`define I2C_BUS_MONITOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define I2CM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define I2CM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ----- design/i2cm_pkg.sv -----
`default_nettype none

package i2cm_pkg;

  localparam int TIME_W        = 48;
  localparam int LEVELS_W      = 8;
  localparam int CHAN_W        = 3;
  localparam int BITS_PER_BYTE = 8;
  localparam int BIT_CNT_W     = 4;
  localparam int CFG_IDX_W     = 1;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_SDA_CHANNEL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCL_CHANNEL = 1'd1;

  // Reset values of the channel selects.
  localparam logic [CHAN_W-1:0] SDA_CHANNEL_RST = 3'd0;
  localparam logic [CHAN_W-1:0] SCL_CHANNEL_RST = 3'd1;

  // Event codes reported in event_kind.
  localparam logic [1:0] KIND_START   = 2'd0;
  localparam logic [1:0] KIND_STOP    = 2'd1;
  localparam logic [1:0] KIND_ADDRESS = 2'd2;
  localparam logic [1:0] KIND_DATA    = 2'd3;

  typedef struct packed {
    logic [LEVELS_W-1:0] line_levels;
    logic [TIME_W-1:0]   sample_time;
    logic                is_baseline;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]          event_kind;
    logic [7:0]          byte_value;
    logic                nak;
    logic [TIME_W-1:0]   begin_time;
    logic [TIME_W-1:0]   end_time;
    logic [TIME_W-1:0]   shortest_period;
  } out_beat_t;

endpackage

`default_nettype wire

// ----- design/i2cm_decode.sv -----
`default_nettype none

module i2cm_decode
  import i2cm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire in_beat_t          item,
  input  wire logic [CHAN_W-1:0] sda_ch,
  input  wire logic [CHAN_W-1:0] scl_ch,
  output logic                   res_valid,
  output out_beat_t              res
);

  logic [LEVELS_W-1:0]  prev_levels_r, prev_levels_nxt;
  logic                 framed_r, framed_nxt;
  logic                 expect_addr_r, expect_addr_nxt;
  logic [BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [7:0]           shift_r, shift_nxt;
  logic [TIME_W-1:0]    byte_start_r, byte_start_nxt;
  logic [TIME_W-1:0]    rise_time_r, rise_time_nxt;
  logic                 rise_seen_r, rise_seen_nxt;
  logic [TIME_W-1:0]    min_period_r, min_period_nxt;

  logic              sda_prev, sda_now, scl_prev, scl_now;
  logic              marker, scl_rise;
  logic [TIME_W-1:0] period;
  logic [TIME_W-1:0] min_upd;

  assign sda_prev = prev_levels_r[sda_ch];
  assign sda_now  = item.line_levels[sda_ch];
  assign scl_prev = prev_levels_r[scl_ch];
  assign scl_now  = item.line_levels[scl_ch];

  // An SDA change with SCL held high is START or STOP; it takes priority.
  assign marker   = (sda_prev != sda_now) && scl_prev && scl_now;
  assign scl_rise = !scl_prev && scl_now;

  assign period  = item.sample_time - rise_time_r;
  assign min_upd = (rise_seen_r && ((min_period_r == '0) || (period < min_period_r)))
                   ? period : min_period_r;

  always_comb begin
    prev_levels_nxt = prev_levels_r;
    framed_nxt      = framed_r;
    expect_addr_nxt = expect_addr_r;
    bit_cnt_nxt     = bit_cnt_r;
    shift_nxt       = shift_r;
    byte_start_nxt  = byte_start_r;
    rise_time_nxt   = rise_time_r;
    rise_seen_nxt   = rise_seen_r;
    min_period_nxt  = min_period_r;
    res_valid       = 1'b0;
    res.event_kind      = KIND_START;
    res.byte_value      = '0;
    res.nak             = 1'b0;
    res.begin_time      = item.sample_time;
    res.end_time        = item.sample_time;
    res.shortest_period = min_period_r;

    if (step) begin
      prev_levels_nxt = item.line_levels;
      if (item.is_baseline) begin
        framed_nxt      = 1'b0;
        expect_addr_nxt = 1'b0;
        bit_cnt_nxt     = '0;
        shift_nxt       = '0;
        byte_start_nxt  = '0;
        rise_time_nxt   = '0;
        rise_seen_nxt   = 1'b0;
        min_period_nxt  = '0;
      end else if (sda_ch != scl_ch) begin
        if (marker) begin
          res_valid       = 1'b1;
          res.event_kind  = sda_now ? KIND_STOP : KIND_START;
          framed_nxt      = !sda_now;
          expect_addr_nxt = !sda_now;
          bit_cnt_nxt     = '0;
          shift_nxt       = '0;
        end else if (scl_rise) begin
          min_period_nxt = min_upd;
          rise_time_nxt  = item.sample_time;
          rise_seen_nxt  = 1'b1;
          if (framed_r) begin
            if (bit_cnt_r < BIT_CNT_W'(BITS_PER_BYTE)) begin
              if (bit_cnt_r == '0) begin
                byte_start_nxt = item.sample_time;
              end
              shift_nxt   = {shift_r[6:0], sda_now};
              bit_cnt_nxt = bit_cnt_r + 1'b1;
            end else begin
              // Ninth clock: acknowledge slot, the byte is complete.
              res_valid           = 1'b1;
              res.event_kind      = expect_addr_r ? KIND_ADDRESS : KIND_DATA;
              res.byte_value      = shift_r;
              res.nak             = sda_now;
              res.begin_time      = byte_start_r;
              res.shortest_period = min_upd;
              expect_addr_nxt     = 1'b0;
              bit_cnt_nxt         = '0;
              shift_nxt           = '0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_levels_r <= '0;
      framed_r      <= 1'b0;
      expect_addr_r <= 1'b0;
      bit_cnt_r     <= '0;
      shift_r       <= '0;
      byte_start_r  <= '0;
      rise_time_r   <= '0;
      rise_seen_r   <= 1'b0;
      min_period_r  <= '0;
    end else begin
      prev_levels_r <= prev_levels_nxt;
      framed_r      <= framed_nxt;
      expect_addr_r <= expect_addr_nxt;
      bit_cnt_r     <= bit_cnt_nxt;
      shift_r       <= shift_nxt;
      byte_start_r  <= byte_start_nxt;
      rise_time_r   <= rise_time_nxt;
      rise_seen_r   <= rise_seen_nxt;
      min_period_r  <= min_period_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/i2c_bus_monitor.sv -----
// Passive I2C bus monitor. Each input beat carries one timestamped sample of
// eight capture lines; two of them, picked by the sda_channel and
// scl_channel registers, are decoded as SDA and SCL. Each output beat
// reports a START, a STOP, or a completed address or data byte with its
// NAK flag, time span and the shortest SCL period seen so far. A sample
// gives at most one output beat; most give none.
// An accepted beat is registered in the input register, is decoded against
// the bus state, and its result is registered in the output register. One
// beat is taken every cycle while the receiver does not stall; the rate is
// set by the single decode stage between the two registers.
// When the receiver stalls, the output beat holds and the input register
// keeps its beat, so in_ready drops only while both are full.
// Configuration writes are taken at any cycle with cfg_we high, with no
// handshake; write them only while the block is idle.
// Synchronous reset empties both registers, clears the bus state and the
// period tracking, and selects line 0 as SDA and line 1 as SCL.
`default_nettype none

module i2c_bus_monitor
  import i2cm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_beat_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_beat_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CHAN_W-1:0]    cfg_wdata
);

  logic [CHAN_W-1:0] sda_ch_r, scl_ch_r;
  logic              in_vld_r;
  in_beat_t          in_beat_r;
  logic              out_vld_r;
  out_beat_t         out_beat_r;

  logic      advance;
  logic      step;
  logic      res_valid;
  out_beat_t res;

  // The decode stage moves whenever the output register is empty or being
  // drained this cycle.
  assign advance  = !out_vld_r || out_ready;
  assign step     = in_vld_r && advance;
  assign in_ready = !in_vld_r || advance;

  assign out_valid = out_vld_r;
  assign out_data  = out_beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sda_ch_r <= SDA_CHANNEL_RST;
      scl_ch_r <= SCL_CHANNEL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SDA_CHANNEL: sda_ch_r <= cfg_wdata;
        CFG_SCL_CHANNEL: scl_ch_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      in_beat_r <= in_data;
    end
  end

  i2cm_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (in_beat_r),
    .sda_ch    (sda_ch_r),
    .scl_ch    (scl_ch_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_beat_r <= res;
    end
  end

endmodule

`default_nettype wire

// ----- design/i2cm_checker.sv -----
`default_nettype none
`include "i2c_bus_monitor_defines.svh"

module i2cm_checker
  import i2cm_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_beat_t out_data
);

  // A stalled output beat holds its contents.
  `I2CM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // START and STOP beats carry no byte and a single marker time.
  `I2CM_ASSERT_NOW(a_marker_fields,
    out_valid && (out_data.event_kind == KIND_START || out_data.event_kind == KIND_STOP),
    out_data.byte_value == '0 && !out_data.nak && out_data.begin_time == out_data.end_time)

  // With no output pending the input side is always open.
  `I2CM_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)

  // A new output beat comes from a sample accepted into the input register.
  `I2CM_ASSERT_NOW(a_out_has_source, $rose(out_valid), $past(in_valid && in_ready, 2))

endmodule

bind i2c_bus_monitor i2cm_checker u_checker (.*);

`default_nettype wire
